[sv/vnta_pkg.sv]
// ----------------------------------------------------------------------------
// vnta_pkg
// Types and fixed constants shared by the vertex normal/tangent accumulator.
// ----------------------------------------------------------------------------
package vnta_pkg;

    // Width of every running sum and of the saturating adders.
    localparam int SUM_W      = 24;
    // Quotient bits kept by the divider; one more is computed to catch overflow.
    localparam int QW         = SUM_W + 1;
    // Width of the shared square-root / divide datapath.
    localparam int IW         = 64;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = 32;
    localparam logic [IW-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam int MAC_W  = 32;
    localparam int PROD_W = 64;
    localparam int TAG_W  = 3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         vertex_index;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
    } t_req;

    typedef struct packed {
        logic [9:0]            read_index;
        logic signed [SUM_W-1:0] normal_sum_x;
        logic signed [SUM_W-1:0] normal_sum_y;
        logic signed [SUM_W-1:0] normal_sum_z;
        logic signed [SUM_W-1:0] tangent_sum_x;
        logic signed [SUM_W-1:0] tangent_sum_y;
        logic signed [SUM_W-1:0] tangent_sum_z;
        logic                  tangent_fault;
    } t_res;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
    } t_vtx;

    typedef struct packed {
        logic signed [SUM_W-1:0] nx;
        logic signed [SUM_W-1:0] ny;
        logic signed [SUM_W-1:0] nz;
        logic signed [SUM_W-1:0] tx;
        logic signed [SUM_W-1:0] ty;
        logic signed [SUM_W-1:0] tz;
    } t_sums;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

    typedef struct packed {
        logic             go;
        logic             first;
        logic             sub;
        logic             last;
        logic [TAG_W-1:0] tag;
    } t_mac_ctl;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } t_mac_st;

endpackage

[sv/vnta_vertex_mem.sv]
// ----------------------------------------------------------------------------
// vnta_vertex_mem
// Vertex store: position and texture coordinate, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module vnta_vertex_mem import vnta_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_vtx          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_vtx          o_rdata
);

    t_vtx mem [DEPTH];
    t_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/vnta_sum_mem.sv]
// ----------------------------------------------------------------------------
// vnta_sum_mem
// Per-vertex normal and tangent sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module vnta_sum_mem import vnta_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_sums         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_sums         o_rdata
);

    t_sums mem [DEPTH];
    t_sums r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/vnta_mac.sv]
// ----------------------------------------------------------------------------
// vnta_mac
// Shared signed multiply-accumulate: one registered product per cycle,
// accumulated or subtracted in the following cycle.
// ----------------------------------------------------------------------------
module vnta_mac import vnta_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [MAC_W-1:0]  i_a,
    input  logic signed [MAC_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_acc,
    output t_mac_st                  o_st
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    t_mac_ctl                 r_ctl;
    t_mac_st                  r_st;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.go) begin
            if (r_ctl.first) begin
                r_acc <= r_ctl.sub ? -r_prod : r_prod;
            end else begin
                r_acc <= r_ctl.sub ? r_acc - r_prod : r_acc + r_prod;
            end
        end
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_st  <= '0;
        end else begin
            r_ctl       <= i_ctl;
            r_st.valid  <= r_ctl.go & r_ctl.last;
            r_st.tag    <= r_ctl.tag;
        end
    end

    assign o_acc = r_acc;
    assign o_st  = r_st;

endmodule

[sv/vnta_iter_unit.sv]
// ----------------------------------------------------------------------------
// vnta_iter_unit
// Shared compare-subtract-shift unit: bit-serial integer square root or
// restoring division, one result bit per cycle.
// ----------------------------------------------------------------------------
module vnta_iter_unit import vnta_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_iter_ctl     i_ctl,
    input  logic [IW-1:0] i_arg_a,
    input  logic [IW-1:0] i_arg_b,
    output logic          o_done,
    output logic [IW-1:0] o_result
);

    logic [IW-1:0]    r_rem;
    logic [IW-1:0]    r_arg;
    logic [IW-1:0]    r_res;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_iter_op         r_op;

    logic [IW-1:0] w_sub;
    logic [IW:0]   w_diff;
    logic          w_ge;

    // In the root loop the trial bit never overlaps the partial root,
    // so an OR forms their sum.
    assign w_sub  = (r_op == OP_SQRT) ? (r_res | r_arg) : r_arg;
    assign w_diff = {1'b0, r_rem} - {1'b0, w_sub};
    assign w_ge   = ~w_diff[IW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_op   <= i_ctl.op;
                r_rem  <= i_arg_a;
                r_res  <= '0;
                r_busy <= 1'b1;
                if (i_ctl.op == OP_SQRT) begin
                    r_arg <= SQRT_BIT0;
                    r_cnt <= CNT_W'(SQRT_STEPS - 1);
                end else begin
                    r_arg <= i_arg_b << QW;
                    r_cnt <= CNT_W'(QW);
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= w_diff[IW-1:0];
                end
                if (r_op == OP_SQRT) begin
                    r_res <= w_ge ? ((r_res >> 1) | r_arg) : (r_res >> 1);
                    r_arg <= r_arg >> 2;
                end else begin
                    r_res <= {r_res[IW-2:0], w_ge};
                    r_arg <= r_arg >> 1;
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[sv/vertex_normal_tangent_accumulator_top.sv]
// ----------------------------------------------------------------------------
// vertex_normal_tangent_accumulator_top
// Per-vertex accumulation of unit face normals and UV tangents over triangles.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// request   in         i_req_valid / o_req_ready    i_req (t_req)
// result    out        o_res_valid / i_res_ready    o_res (t_res)
//
// After reset all VERTEX_DEPTH entries of the sum store are cleared, one per
// cycle, with o_req_ready low. A load is written straight from the request; a
// read passes through an address state and an output state, plus any wait for
// the result register. A triangle uses the shared divide / square-root unit
// for one root and six quotients, and the normalizing shift moves one bit per
// cycle. A zero UV determinant skips the three tangent quotients; a degenerate
// triangle skips the root and the normal quotients. o_req_ready stays low
// until the current request is finished.
// ----------------------------------------------------------------------------
module vertex_normal_tangent_accumulator_top import vnta_pkg::*; #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    localparam logic [TAG_W-1:0] TAG_DET  = 3'd3;
    localparam logic [TAG_W-1:0] TAG_NUM0 = 3'd4;
    localparam logic [TAG_W-1:0] TAG_SQ   = 3'd7;
    localparam logic [QW-1:0]    UNIT_ONE = QW'(16384);
    localparam logic [QW-1:0]    TAN_MAX  = QW'(1) << SUM_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_VA, S_VB, S_VC, S_VD, S_MUL, S_NCHK, S_NSHIFT, S_SQ,
        S_SQRT_GO, S_SQRT_WAIT, S_NDIV_GO, S_NDIV_WAIT, S_TCHK, S_TDIV_GO,
        S_TDIV_WAIT, S_ACC_RD, S_ACC_WR, S_RD_ADDR, S_RD_OUT
    } t_state;

    function automatic logic signed [16:0] sdiff(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        sdiff = {b[15], b} - {a[15], a};
    endfunction

    function automatic logic signed [16:0] udiff(input logic [15:0] a,
                                                 input logic [15:0] b);
        udiff = {1'b0, b} - {1'b0, a};
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W+1:0] b
    );
        logic signed [SUM_W+2:0] s;
        s = {{3{a[SUM_W-1]}}, a} + {b[SUM_W+1], b};
        if (s[SUM_W+2:SUM_W-1] == '0 || s[SUM_W+2:SUM_W-1] == '1) begin
            sat_add = s[SUM_W-1:0];
        end else if (s[SUM_W+2]) begin
            sat_add = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sat_add = {1'b0, {(SUM_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SUM_W+1:0] ext_nrm(input logic signed [15:0] n);
        ext_nrm = {{(SUM_W-14){n[15]}}, n};
    endfunction

    t_state r_state;
    logic [AW-1:0]         r_idx [3];
    logic [9:0]            r_rd_index;
    logic                  r_rd_ok;
    t_vtx                  r_pa;
    logic signed [16:0]    r_e0 [3];
    logic signed [16:0]    r_e1 [3];
    logic signed [16:0]    r_du1, r_dv1, r_du2, r_dv2;
    logic [3:0]            r_step;
    logic signed [34:0]    r_cr [3];
    logic signed [34:0]    r_det;
    logic signed [34:0]    r_num [3];
    logic [34:0]           r_mag [3];
    logic [61:0]           r_s;
    logic [31:0]           r_len;
    logic [1:0]            r_comp;
    logic [1:0]            r_corner;
    logic signed [15:0]    r_nrm [3];
    logic signed [SUM_W+1:0] r_tan [3];
    logic                  r_tan_ok;
    logic                  r_fault;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_out_valid;
    t_res                  r_out;

    logic            w_accept;
    logic            w_a_ok, w_b_ok, w_c_ok;
    logic            vtx_we;
    logic [AW-1:0]   vtx_raddr;
    t_vtx            vtx_wdata, vtx_rdata;
    logic            sum_we;
    logic [AW-1:0]   sum_waddr, sum_raddr;
    t_sums           sum_wdata, sum_rdata;
    t_mac_ctl        mac_ctl;
    t_mac_st         mac_st;
    logic signed [MAC_W-1:0]  mac_a, mac_b;
    logic signed [PROD_W-1:0] mac_acc;
    t_iter_ctl       it_ctl;
    logic [IW-1:0]   it_a, it_b, it_result;
    logic            it_done;
    logic            w_mag_hi, w_mag_lo;
    logic [34:0]     w_nmag, w_dmag;
    logic [QW-1:0]   w_q, w_qn, w_qt;
    logic            w_out_load;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid & o_req_ready;
    assign w_a_ok      = 32'(i_req.vertex_index) < VERTEX_DEPTH;
    assign w_b_ok      = 32'(i_req.corner_b) < VERTEX_DEPTH;
    assign w_c_ok      = 32'(i_req.corner_c) < VERTEX_DEPTH;

    // Loads are written straight from the request.
    assign vtx_we          = w_accept && (i_req.mode == MODE_LOAD) && w_a_ok;
    assign vtx_wdata.pos_x = i_req.pos_x;
    assign vtx_wdata.pos_y = i_req.pos_y;
    assign vtx_wdata.pos_z = i_req.pos_z;
    assign vtx_wdata.tex_u = i_req.tex_u;
    assign vtx_wdata.tex_v = i_req.tex_v;

    always_comb begin
        unique case (r_state)
            S_VB:    vtx_raddr = r_idx[1];
            S_VC:    vtx_raddr = r_idx[2];
            default: vtx_raddr = r_idx[0];
        endcase
    end

    vnta_vertex_mem #(.DEPTH(VERTEX_DEPTH), .AW(AW)) u_vertex_mem (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (AW'(i_req.vertex_index)),
        .i_wdata (vtx_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    assign sum_raddr = (r_state == S_ACC_RD || r_state == S_ACC_WR) ? r_idx[r_corner]
                                                                     : r_idx[0];

    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = r_idx[r_corner];
        sum_wdata = '0;
        if (r_state == S_CLR) begin
            sum_we    = 1'b1;
            sum_waddr = r_clr_addr;
        end else if (r_state == S_ACC_WR) begin
            sum_we       = 1'b1;
            sum_wdata.nx = sat_add(sum_rdata.nx, ext_nrm(r_nrm[0]));
            sum_wdata.ny = sat_add(sum_rdata.ny, ext_nrm(r_nrm[1]));
            sum_wdata.nz = sat_add(sum_rdata.nz, ext_nrm(r_nrm[2]));
            sum_wdata.tx = r_tan_ok ? sat_add(sum_rdata.tx, r_tan[0]) : sum_rdata.tx;
            sum_wdata.ty = r_tan_ok ? sat_add(sum_rdata.ty, r_tan[1]) : sum_rdata.ty;
            sum_wdata.tz = r_tan_ok ? sat_add(sum_rdata.tz, r_tan[2]) : sum_rdata.tz;
        end
    end

    vnta_sum_mem #(.DEPTH(VERTEX_DEPTH), .AW(AW)) u_sum_mem (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // Product schedule: pairs p1 - p2 for the cross product, the UV
    // determinant and the tangent numerators, then the sum of squares.
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        if (r_state == S_MUL && r_step < 4'd14) begin
            mac_ctl.go    = 1'b1;
            mac_ctl.first = ~r_step[0];
            mac_ctl.sub   = r_step[0];
            mac_ctl.last  = r_step[0];
            mac_ctl.tag   = r_step[3:1];
            case (r_step)
                4'd0:    begin mac_a = MAC_W'(r_e0[1]); mac_b = MAC_W'(r_e1[2]); end
                4'd1:    begin mac_a = MAC_W'(r_e0[2]); mac_b = MAC_W'(r_e1[1]); end
                4'd2:    begin mac_a = MAC_W'(r_e0[2]); mac_b = MAC_W'(r_e1[0]); end
                4'd3:    begin mac_a = MAC_W'(r_e0[0]); mac_b = MAC_W'(r_e1[2]); end
                4'd4:    begin mac_a = MAC_W'(r_e0[0]); mac_b = MAC_W'(r_e1[1]); end
                4'd5:    begin mac_a = MAC_W'(r_e0[1]); mac_b = MAC_W'(r_e1[0]); end
                4'd6:    begin mac_a = MAC_W'(r_du1);   mac_b = MAC_W'(r_dv2);   end
                4'd7:    begin mac_a = MAC_W'(r_dv1);   mac_b = MAC_W'(r_du2);   end
                4'd8:    begin mac_a = MAC_W'(r_e0[0]); mac_b = MAC_W'(r_dv2);   end
                4'd9:    begin mac_a = MAC_W'(r_e1[0]); mac_b = MAC_W'(r_dv1);   end
                4'd10:   begin mac_a = MAC_W'(r_e0[1]); mac_b = MAC_W'(r_dv2);   end
                4'd11:   begin mac_a = MAC_W'(r_e1[1]); mac_b = MAC_W'(r_dv1);   end
                4'd12:   begin mac_a = MAC_W'(r_e0[2]); mac_b = MAC_W'(r_dv2);   end
                4'd13:   begin mac_a = MAC_W'(r_e1[2]); mac_b = MAC_W'(r_dv1);   end
                default: begin mac_a = '0;              mac_b = '0;              end
            endcase
        end else if (r_state == S_SQ && r_step < 4'd3) begin
            mac_ctl.go    = 1'b1;
            mac_ctl.first = (r_step == 4'd0);
            mac_ctl.last  = (r_step == 4'd2);
            mac_ctl.tag   = TAG_SQ;
            mac_a         = $signed({2'b00, r_mag[r_step[1:0]][29:0]});
            mac_b         = mac_a;
        end
    end

    vnta_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc),
        .o_st    (mac_st)
    );

    assign w_nmag = r_num[r_comp][34] ? 35'(-r_num[r_comp]) : 35'(r_num[r_comp]);
    assign w_dmag = r_det[34] ? 35'(-r_det) : 35'(r_det);

    always_comb begin
        it_ctl.start = (r_state == S_SQRT_GO) || (r_state == S_NDIV_GO)
                    || (r_state == S_TDIV_GO);
        it_ctl.op    = (r_state == S_SQRT_GO) ? OP_SQRT : OP_DIV;
        it_b         = '0;
        unique case (r_state)
            S_SQRT_GO: it_a = IW'(r_s);
            S_NDIV_GO: begin
                it_a = (IW'(r_mag[r_comp][29:0]) << 14) + IW'(r_len >> 1);
                it_b = IW'(r_len);
            end
            default: begin
                it_a = (IW'(w_nmag) << 16) + IW'(w_dmag >> 1);
                it_b = IW'(w_dmag);
            end
        endcase
    end

    vnta_iter_unit u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (it_ctl),
        .i_arg_a  (it_a),
        .i_arg_b  (it_b),
        .o_done   (it_done),
        .o_result (it_result)
    );

    // A set top quotient bit means the true quotient does not fit.
    assign w_q  = it_result[QW] ? '1 : it_result[QW-1:0];
    assign w_qn = (w_q > UNIT_ONE) ? UNIT_ONE : w_q;
    assign w_qt = (w_q > TAN_MAX) ? TAN_MAX : w_q;

    assign w_mag_hi = (r_mag[0][34:30] != '0) || (r_mag[1][34:30] != '0)
                   || (r_mag[2][34:30] != '0);
    assign w_mag_lo = (r_mag[0][34:29] == '0) && (r_mag[1][34:29] == '0)
                   && (r_mag[2][34:29] == '0);

    assign w_out_load = (r_state == S_RD_OUT) && (!r_out_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_comp      <= '0;
            r_corner    <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mac_st.valid) begin
                if (mac_st.tag == TAG_SQ) begin
                    r_s <= mac_acc[61:0];
                end else if (mac_st.tag == TAG_DET) begin
                    r_det <= mac_acc[34:0];
                end else if (mac_st.tag < TAG_DET) begin
                    r_cr[mac_st.tag[1:0]] <= mac_acc[34:0];
                end else begin
                    r_num[2'(mac_st.tag - TAG_NUM0)] <= mac_acc[34:0];
                end
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(VERTEX_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx[0]   <= AW'(i_req.vertex_index);
                        r_idx[1]   <= AW'(i_req.corner_b);
                        r_idx[2]   <= AW'(i_req.corner_c);
                        r_rd_index <= i_req.vertex_index;
                        r_rd_ok    <= w_a_ok;
                        unique case (i_req.mode)
                            MODE_TRI: begin
                                if (w_a_ok && w_b_ok && w_c_ok) begin
                                    r_state <= S_VA;
                                end
                            end
                            MODE_READ: r_state <= S_RD_ADDR;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_VA: r_state <= S_VB;
                S_VB: begin
                    r_pa    <= vtx_rdata;
                    r_state <= S_VC;
                end
                S_VC: begin
                    r_e0[0] <= sdiff(r_pa.pos_x, vtx_rdata.pos_x);
                    r_e0[1] <= sdiff(r_pa.pos_y, vtx_rdata.pos_y);
                    r_e0[2] <= sdiff(r_pa.pos_z, vtx_rdata.pos_z);
                    r_du1   <= udiff(r_pa.tex_u, vtx_rdata.tex_u);
                    r_dv1   <= udiff(r_pa.tex_v, vtx_rdata.tex_v);
                    r_state <= S_VD;
                end
                S_VD: begin
                    r_e1[0] <= sdiff(r_pa.pos_x, vtx_rdata.pos_x);
                    r_e1[1] <= sdiff(r_pa.pos_y, vtx_rdata.pos_y);
                    r_e1[2] <= sdiff(r_pa.pos_z, vtx_rdata.pos_z);
                    r_du2   <= udiff(r_pa.tex_u, vtx_rdata.tex_u);
                    r_dv2   <= udiff(r_pa.tex_v, vtx_rdata.tex_v);
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // Two extra steps drain the multiplier pipeline.
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    r_tan_ok <= (r_det != '0);
                    if (r_det == '0) begin
                        r_fault <= 1'b1;
                    end
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_cr[i][34] ? 35'(-r_cr[i]) : 35'(r_cr[i]);
                    end
                    if (r_cr[0] == '0 && r_cr[1] == '0 && r_cr[2] == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_nrm[i] <= '0;
                        end
                        r_state <= S_TCHK;
                    end else begin
                        r_state <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    // Bring the largest magnitude into [2^29, 2^30), one bit per cycle.
                    if (w_mag_hi) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else if (w_mag_lo) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                    end else begin
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd4) begin
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (it_done) begin
                        r_len   <= it_result[31:0];
                        r_comp  <= '0;
                        r_state <= S_NDIV_GO;
                    end
                end
                S_NDIV_GO: r_state <= S_NDIV_WAIT;
                S_NDIV_WAIT: begin
                    if (it_done) begin
                        r_nrm[r_comp] <= r_cr[r_comp][34] ? -$signed({1'b0, w_qn[14:0]})
                                                          : $signed({1'b0, w_qn[14:0]});
                        if (r_comp == 2'd2) begin
                            r_state <= S_TCHK;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= S_NDIV_GO;
                        end
                    end
                end
                S_TCHK: begin
                    r_comp   <= '0;
                    r_corner <= '0;
                    r_state  <= r_tan_ok ? S_TDIV_GO : S_ACC_RD;
                end
                S_TDIV_GO: r_state <= S_TDIV_WAIT;
                S_TDIV_WAIT: begin
                    if (it_done) begin
                        r_tan[r_comp] <= (r_num[r_comp][34] ^ r_det[34])
                                       ? -$signed({1'b0, w_qt}) : $signed({1'b0, w_qt});
                        if (r_comp == 2'd2) begin
                            r_corner <= '0;
                            r_state  <= S_ACC_RD;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= S_TDIV_GO;
                        end
                    end
                end
                S_ACC_RD: r_state <= S_ACC_WR;
                S_ACC_WR: begin
                    if (r_corner == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_corner <= r_corner + 1'b1;
                        r_state  <= S_ACC_RD;
                    end
                end
                S_RD_ADDR: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    if (w_out_load) begin
                        r_out_valid         <= 1'b1;
                        r_out.read_index    <= r_rd_index;
                        r_out.normal_sum_x  <= r_rd_ok ? sum_rdata.nx : '0;
                        r_out.normal_sum_y  <= r_rd_ok ? sum_rdata.ny : '0;
                        r_out.normal_sum_z  <= r_rd_ok ? sum_rdata.nz : '0;
                        r_out.tangent_sum_x <= r_rd_ok ? sum_rdata.tx : '0;
                        r_out.tangent_sum_y <= r_rd_ok ? sum_rdata.ty : '0;
                        r_out.tangent_sum_z <= r_rd_ok ? sum_rdata.tz : '0;
                        r_out.tangent_fault <= r_fault;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
